// File: sv/olpe_pkg.sv
`timescale 1ns / 1ps

package olpe_pkg;

    // Request codes
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_END   = 3'd1;
    localparam logic [2:0] REQ_INS_POS   = 3'd2;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [2:0] REQ_DEL_END   = 3'd4;
    localparam logic [2:0] REQ_DEL_POS   = 3'd5;
    localparam logic [2:0] REQ_LIST      = 3'd6;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_OOB   = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    // Operation broadcast along the cell chain
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [7:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               last;
    } res_t;

endpackage

// File: sv/ordered_list_positional_edit.sv
`timescale 1ns / 1ps
// Edits (insert, delete): result registered on acceptance, valid the cycle after; one
// edit per cycle while the output is not stalled. List all: count results, one per cycle
// while the output is not stalled, as the chain of cells rotates by one; no request is
// taken until the last one is registered. An empty list answers with a single EMPTY result.
// Reset (rst_n low, asynchronous): count cleared, sequencer idle, output empty.
// Cell contents are not reset and are read only below count.

module ordered_list_positional_edit #(
    parameter int DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  olpe_pkg::req_t  req,
    output logic            out_valid,
    input  logic            out_ready,
    output olpe_pkg::res_t  res
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      list_left_reg, list_left_next;
    logic               out_valid_reg, out_valid_next;
    olpe_pkg::res_t     out_data_reg, out_data_next;

    olpe_pkg::cell_op_t cell_op;
    logic [IW-1:0]      edit_idx;
    logic [IW-1:0]      last_idx;
    logic signed [31:0] cell_q [DEPTH];
    logic signed [31:0] del_value;

    logic               out_free;
    logic               accept;
    logic [8:0]         pos_w;
    logic [8:0]         count_w;
    logic               full;
    logic               empty;
    logic               ins_pos_ok;
    logic               del_pos_ok;

    // Decode position checks
    assign pos_w      = {1'b0, req.position};
    assign count_w    = 9'(count_reg);
    assign full       = (count_reg == FULL_COUNT);
    assign empty      = (count_reg == '0);
    assign ins_pos_ok = (req.position != 8'd0) && (pos_w <= count_w + 9'd1);
    assign del_pos_ok = (req.position != 8'd0) && (pos_w <= count_w);
    assign last_idx   = IW'(count_reg - CW'(1));

    // Work out the zero-based slot of an edit
    always_comb
    begin
        unique case (req.req_type)
            olpe_pkg::REQ_INS_END: edit_idx = IW'(count_reg);
            olpe_pkg::REQ_DEL_END: edit_idx = IW'(count_reg - CW'(1));
            olpe_pkg::REQ_INS_POS,
            olpe_pkg::REQ_DEL_POS: edit_idx = IW'(req.position - 8'd1);
            default:               edit_idx = '0;
        endcase
    end

    // Select the word under the edit slot
    always_comb
    begin
        del_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (edit_idx == IW'(i))
                del_value = cell_q[i];
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // Sequence edits and list walks
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        list_left_next = list_left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        cell_op        = olpe_pkg::OP_HOLD;

        if (state_reg == ST_LIST)
        begin
            if (out_free)
            begin
                out_valid_next         = 1'b1;
                out_data_next.status   = olpe_pkg::STAT_OK;
                out_data_next.data_out = cell_q[0];
                out_data_next.last     = (list_left_reg == CW'(1));
                cell_op                = olpe_pkg::OP_ROT;
                list_left_next         = list_left_reg - CW'(1);
                if (list_left_reg == CW'(1))
                    state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            out_data_next.status   = olpe_pkg::STAT_OK;
            out_data_next.data_out = '0;
            out_data_next.last     = 1'b1;
            unique case (req.req_type)
                olpe_pkg::REQ_INS_FRONT,
                olpe_pkg::REQ_INS_END,
                olpe_pkg::REQ_INS_POS:
                begin
                    out_valid_next = 1'b1;
                    if (full)
                        out_data_next.status = olpe_pkg::STAT_FULL;
                    else if (req.req_type == olpe_pkg::REQ_INS_POS && !ins_pos_ok)
                        out_data_next.status = olpe_pkg::STAT_OOB;
                    else
                    begin
                        cell_op    = olpe_pkg::OP_INS;
                        count_next = count_reg + CW'(1);
                    end
                end
                olpe_pkg::REQ_DEL_FRONT,
                olpe_pkg::REQ_DEL_END,
                olpe_pkg::REQ_DEL_POS:
                begin
                    out_valid_next = 1'b1;
                    if (empty)
                        out_data_next.status = olpe_pkg::STAT_EMPTY;
                    else if (req.req_type == olpe_pkg::REQ_DEL_POS && !del_pos_ok)
                        out_data_next.status = olpe_pkg::STAT_OOB;
                    else
                    begin
                        cell_op                = olpe_pkg::OP_DEL;
                        count_next             = count_reg - CW'(1);
                        out_data_next.data_out = del_value;
                    end
                end
                olpe_pkg::REQ_LIST:
                begin
                    if (empty)
                    begin
                        out_valid_next       = 1'b1;
                        out_data_next.status = olpe_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        state_next     = ST_LIST;
                        list_left_next = count_reg;
                    end
                end
                default:
                begin
                    // drop the unused code: no result, no change
                    out_data_next = out_data_reg;
                end
            endcase
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            list_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_left_reg <= list_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = out_data_reg;

    // Chain of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [31:0] left_w;
        logic signed [31:0] right_w;

        if (g == 0)
        begin : g_head
            assign left_w = '0;
        end
        else
        begin : g_body
            assign left_w = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_mid
            assign right_w = cell_q[g+1];
        end

        olpe_cell #(
            .IW    (IW),
            .INDEX (g)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op),
            .idx       (edit_idx),
            .last_idx  (last_idx),
            .ins_value (req.value),
            .left_q    (left_w),
            .right_q   (right_w),
            .head_q    (cell_q[0]),
            .q         (cell_q[g])
        );
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LIST |-> list_left_reg != '0 && list_left_reg <= count_reg)
        else $error("list walk counter out of range");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (req.req_type == olpe_pkg::REQ_INS_FRONT
            || req.req_type == olpe_pkg::REQ_INS_END
            || req.req_type == olpe_pkg::REQ_INS_POS)) |=> $stable(count_reg))
        else $error("insert into full store changed count");
`endif

endmodule

// File: sv/olpe_cell.sv
`timescale 1ns / 1ps

module olpe_cell #(
    parameter int IW    = 4,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  olpe_pkg::cell_op_t  op,
    input  logic [IW-1:0]       idx,
    input  logic [IW-1:0]       last_idx,
    input  logic signed [31:0]  ins_value,
    input  logic signed [31:0]  left_q,
    input  logic signed [31:0]  right_q,
    input  logic signed [31:0]  head_q,
    output logic signed [31:0]  q
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // Pick this cell's next word from the broadcast operation
    always_comb
    begin
        value_next = value_reg;
        unique case (op)
            olpe_pkg::OP_INS:
            begin
                if (MY_IDX == idx)
                    value_next = ins_value;
                else if (MY_IDX > idx)
                    value_next = left_q;
            end
            olpe_pkg::OP_DEL:
            begin
                if (MY_IDX >= idx && MY_IDX < last_idx)
                    value_next = right_q;
            end
            olpe_pkg::OP_ROT:
            begin
                if (MY_IDX < last_idx)
                    value_next = right_q;
                else if (MY_IDX == last_idx)
                    value_next = head_q;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Hold the word
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q = value_reg;

endmodule

// File: tb/ordered_list_positional_edit_tb.sv
`timescale 1ns / 1ps

module ordered_list_positional_edit_tb;

    localparam int LIST_DEPTH = 16;
    // Code outside the request set; the block must swallow it silently
    localparam logic [2:0] REQ_UNUSED = 3'd7;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam int WORDS_PER_PHASE = 75;

    // Shadow copy of the list: turns each accepted request into the result
    // words it should produce, and checks returned words against them
    class list_shadow;
        logic signed [31:0] cells [LIST_DEPTH];
        int unsigned        fill;
        olpe_pkg::res_t     awaited_results [$];
        int unsigned        errors;
        int unsigned        results_checked;

        function new();
            fill = 0;
            errors = 0;
            results_checked = 0;
        endfunction

        function void note_request(olpe_pkg::req_t r);
            olpe_pkg::res_t     o;
            int                 idx;
            int                 i;
            logic signed [31:0] v;
            o.status = olpe_pkg::STAT_OK;
            o.data_out = '0;
            o.last = 1'b1;
            case (r.req_type)
                olpe_pkg::REQ_INS_FRONT, olpe_pkg::REQ_INS_END, olpe_pkg::REQ_INS_POS:
                begin
                    // full takes precedence over a bad position
                    if (fill >= LIST_DEPTH)
                        o.status = olpe_pkg::STAT_FULL;
                    else if (r.req_type == olpe_pkg::REQ_INS_POS &&
                             (r.position < 1 || r.position > fill + 1))
                        o.status = olpe_pkg::STAT_OOB;
                    else
                    begin
                        if (r.req_type == olpe_pkg::REQ_INS_FRONT)
                            idx = 0;
                        else if (r.req_type == olpe_pkg::REQ_INS_END)
                            idx = fill;
                        else
                            idx = r.position - 1;
                        for (i = fill; i > idx; i--)
                            cells[i] = cells[i - 1];
                        cells[idx] = r.value;
                        fill++;
                    end
                    awaited_results.push_back(o);
                end
                olpe_pkg::REQ_DEL_FRONT, olpe_pkg::REQ_DEL_END, olpe_pkg::REQ_DEL_POS:
                begin
                    // empty takes precedence over a bad position
                    if (fill == 0)
                        o.status = olpe_pkg::STAT_EMPTY;
                    else if (r.req_type == olpe_pkg::REQ_DEL_POS &&
                             (r.position < 1 || r.position > fill))
                        o.status = olpe_pkg::STAT_OOB;
                    else
                    begin
                        if (r.req_type == olpe_pkg::REQ_DEL_FRONT)
                            idx = 0;
                        else if (r.req_type == olpe_pkg::REQ_DEL_END)
                            idx = fill - 1;
                        else
                            idx = r.position - 1;
                        v = cells[idx];
                        for (i = idx; i + 1 < fill; i++)
                            cells[i] = cells[i + 1];
                        fill--;
                        o.data_out = v;
                    end
                    awaited_results.push_back(o);
                end
                olpe_pkg::REQ_LIST:
                begin
                    if (fill == 0)
                    begin
                        o.status = olpe_pkg::STAT_EMPTY;
                        awaited_results.push_back(o);
                    end
                    else
                    begin
                        for (i = 0; i < fill; i++)
                        begin
                            o.data_out = cells[i];
                            o.last = (i + 1 == fill);
                            awaited_results.push_back(o);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(olpe_pkg::res_t got);
            olpe_pkg::res_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result word with nothing awaited: status %0d data_out %0d last %0b",
                       got.status, got.data_out, got.last);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            results_checked++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.data_out !== want.data_out)
            begin
                $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    olpe_pkg::req_t req = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    olpe_pkg::res_t res;

    list_shadow  shadow;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned words_sent = 0;
    int unsigned full_hits = 0;
    int unsigned empty_hits = 0;
    bit          grow_mode = 1'b1;

    ordered_list_positional_edit #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req(req),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .res(res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the receiver at random, at the rate set for the current phase
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= stall_pct);
    end

    // Check every result word taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_result(res);
    end

    // Hold valid and payload until the word is taken; idle beforehand at random
    task automatic send_word(input olpe_pkg::req_t r);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        req = r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        shadow.note_request(r);
        words_sent++;
    endtask

    task automatic send_req(input logic [2:0] t, input logic signed [31:0] v,
                            input logic [7:0] p);
        olpe_pkg::req_t r;
        r.req_type = t;
        r.value = v;
        r.position = p;
        send_word(r);
    endtask

    // Drop valid and wait until every awaited result word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (shadow.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed edits with positions in range; drift the fill level
    // between empty and full so both ends are reached repeatedly
    function automatic olpe_pkg::req_t random_request();
        olpe_pkg::req_t r;
        int unsigned    k;
        int unsigned    n;
        n = shadow.fill;
        if (n >= LIST_DEPTH)
        begin
            grow_mode = 1'b0;
            full_hits++;
        end
        else if (n == 0)
        begin
            grow_mode = 1'b1;
            empty_hits++;
        end
        k = $urandom_range(99);
        if (k < 4)
            r.req_type = REQ_UNUSED;
        else if (k < 14)
            r.req_type = olpe_pkg::REQ_LIST;
        else if (k < (grow_mode ? 70 : 40))
            r.req_type = 3'(olpe_pkg::REQ_INS_FRONT + $urandom_range(2));
        else
            r.req_type = 3'(olpe_pkg::REQ_DEL_FRONT + $urandom_range(2));
        case ($urandom_range(9))
            0: r.value = VAL_MAX;
            1: r.value = VAL_MIN;
            2: r.value = 32'sd0;
            default: r.value = $urandom;
        endcase
        if ($urandom_range(3) == 0)
            r.position = 8'($urandom_range(255));
        else if (r.req_type == olpe_pkg::REQ_INS_POS)
            r.position = 8'($urandom_range(n + 1, 1));
        else if (n > 0)
            r.position = 8'($urandom_range(n, 1));
        else
            r.position = 8'($urandom_range(1));
        return r;
    endfunction

    initial
    begin
        int unsigned    idle_set [4];
        int unsigned    stall_set [4];
        int unsigned    done;
        olpe_pkg::req_t r;
        idle_set = '{0, 46, 0, 32};
        stall_set = '{0, 0, 46, 32};
        shadow = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, bounds, extremes, only entry, full store
        send_req(olpe_pkg::REQ_LIST, 32'sd0, 8'd0);
        send_req(olpe_pkg::REQ_DEL_FRONT, 32'sd0, 8'd0);
        send_req(olpe_pkg::REQ_DEL_END, 32'sd0, 8'd0);
        send_req(olpe_pkg::REQ_DEL_POS, 32'sd0, 8'd0);
        send_req(olpe_pkg::REQ_INS_POS, 32'sd7, 8'd0);
        send_req(olpe_pkg::REQ_INS_POS, 32'sd7, 8'd2);
        send_req(olpe_pkg::REQ_INS_POS, 32'sd5, 8'd1);
        send_req(olpe_pkg::REQ_DEL_POS, 32'sd0, 8'd1);
        send_req(olpe_pkg::REQ_INS_FRONT, VAL_MAX, 8'hFF);
        send_req(olpe_pkg::REQ_INS_END, VAL_MIN, 8'd0);
        send_req(olpe_pkg::REQ_INS_POS, -32'sd1, 8'd2);
        send_req(olpe_pkg::REQ_INS_POS, 32'sd0, 8'd4);
        send_req(olpe_pkg::REQ_LIST, 32'sd0, 8'd0);
        send_req(olpe_pkg::REQ_DEL_POS, 32'sd0, 8'd5);
        send_req(olpe_pkg::REQ_DEL_POS, 32'sd0, 8'd255);
        send_req(olpe_pkg::REQ_DEL_POS, 32'sd0, 8'd2);
        send_req(olpe_pkg::REQ_DEL_END, 32'sd0, 8'd0);
        send_req(REQ_UNUSED, VAL_MAX, 8'hFF);
        while (shadow.fill < LIST_DEPTH)
            send_req(olpe_pkg::REQ_INS_END, $urandom, 8'd0);
        send_req(olpe_pkg::REQ_INS_FRONT, 32'sd1, 8'd1);
        send_req(olpe_pkg::REQ_INS_POS, 32'sd1, 8'd0);
        send_req(olpe_pkg::REQ_LIST, 32'sd0, 8'd0);
        send_req(olpe_pkg::REQ_DEL_FRONT, 32'sd0, 8'd0);
        wait_drained();

        // Random: one phase per pacing mix, draining between phases
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            done = 0;
            while (done < WORDS_PER_PHASE)
            begin
                r = random_request();
                send_word(r);
                if (r.req_type != REQ_UNUSED)
                    done++;
            end
            wait_drained();
        end

        // Let any stray output show up before the verdict
        stall_pct = 0;
        repeat (LIST_DEPTH + 8) @(posedge clk);
        $display("summary: %0d request words sent, %0d result words checked",
                 words_sent, shadow.results_checked);
        $display("summary: store seen full %0d times, empty %0d times, four pacing mixes",
                 full_hits, empty_hits);
        if (shadow.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
sv/olpe_pkg.sv
sv/olpe_cell.sv
sv/ordered_list_positional_edit.sv
tb/ordered_list_positional_edit_tb.sv
